### sv/bdlp_pkg.sv
// Package for the button debouncer with long-press detection.
// Holds event and status codes, register indexes and the configuration struct.
// No dependencies.
package bdlp_pkg;

  // Fixed field widths
  localparam int unsigned LevelsW   = 3;
  localparam int unsigned EventW    = 3;
  localparam int unsigned DebW      = 10;
  localparam int unsigned LongW     = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned NumFields = 3;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd1;

  // Reset values of the registers
  localparam logic [DebW-1:0]  DEB_RESET  = 10'd20;
  localparam logic [LongW-1:0] LONG_RESET = 16'd3000;

  // Per-button status
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_PRESS = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  // Event codes
  localparam logic [EventW-1:0] EV_NONE       = 3'd0;
  localparam logic [EventW-1:0] EV_PRESS      = 3'd1;
  localparam logic [EventW-1:0] EV_LONG       = 3'd2;
  localparam logic [EventW-1:0] EV_PRESS_FREE = 3'd3;
  localparam logic [EventW-1:0] EV_LONG_FREE  = 3'd4;

  // Configuration shared by all buttons
  typedef struct packed {
    logic [DebW-1:0]  debounce;
    logic [LongW-1:0] long_press;
  } cfg_t;

endpackage

### sv/button_debounce_long_press.sv
// Debouncer with press and long-press detection for up to three buttons. Each input
// beat is one tick of raw active-low key levels; each output beat holds one event
// code per button. One tick is accepted every cycle while the result register is
// not stalled. A tick lands in the input register when accepted and its events in
// the result register after it, from which the result beat is offered. The
// per-button update is a single pass of compare logic between the two registers;
// only a stalled result holds the input back. The user must write configuration
// through cfg_we_i/cfg_idx_i/cfg_data_i only while no tick is in flight; the block
// itself does not enforce this.
// Depends on bdlp_pkg and bdlp_button.
module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tick input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [LevelsW-1:0]  key_levels_i,
  // event output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [EventW-1:0]   event_0_o,
  output logic [EventW-1:0]   event_1_o,
  output logic [EventW-1:0]   event_2_o,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned NumLive = (NUM_BUTTONS < NumFields) ? NUM_BUTTONS : NumFields;

  cfg_t               cfg_q;
  logic               s1_valid_q;
  logic [LevelsW-1:0] levels_q;
  logic               advance;
  logic               out_valid_q;
  logic [EventW-1:0]  ev      [NumFields];
  logic [EventW-1:0]  ev_q    [NumFields];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= DEB_RESET;
      cfg_q.long_press <= LONG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE:   cfg_q.debounce   <= cfg_data_i[DebW-1:0];
        CFG_LONG_PRESS: cfg_q.long_press <= cfg_data_i[LongW-1:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  // Handshake: the input stage moves on when the result register is free or leaving
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      levels_q <= key_levels_i;
    end
  end

  // Per-button logic
  for (genvar i = 0; i < NumFields; i++) begin : g_btn
    if (i < NumLive) begin : g_live
      bdlp_button u_btn (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (s1_valid_q && advance),
        .level_i (levels_q[i]),
        .cfg_i   (cfg_q),
        .event_o (ev[i])
      );
    end else begin : g_idle
      assign ev[i] = EV_NONE;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      ev_q <= ev;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_0_o   = ev_q[0];
  assign event_1_o   = ev_q[1];
  assign event_2_o   = ev_q[2];

  // A tick that moves on from the input stage lands in the result register
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && advance |=> out_valid_q)
    else $error("tick lost between stages");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(levels_q))
    else $error("stalled tick changed");

  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("empty input stage not ready");

endmodule

### sv/bdlp_button.sv
// One button: level latch, saturating stable-tick counter and press status.
// Event is combinational from the current tick's level; state updates on en_i.
// Depends on bdlp_pkg.
module bdlp_button
  import bdlp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              level_i,
  input  cfg_t              cfg_i,
  output logic [EventW-1:0] event_o
);

  logic              latch_q, latch_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [1:0]        status_q, status_d;
  logic [CountW-1:0] cnt_inc;
  logic              past_deb, past_long;

  // Saturating increment and threshold compares
  assign cnt_inc   = (cnt_q == {CountW{1'b1}}) ? cnt_q : cnt_q + CountW'(1);
  assign past_deb  = cnt_inc > CountW'(cfg_i.debounce);
  assign past_long = cnt_inc > cfg_i.long_press;

  // Next state and event
  always_comb begin
    latch_d  = latch_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    event_o  = EV_NONE;
    if (level_i != latch_q) begin
      latch_d = level_i;
      cnt_d   = '0;
    end else begin
      cnt_d = cnt_inc;
      if (past_deb) begin
        if (!level_i) begin
          if (status_q == ST_NONE) begin
            status_d = ST_PRESS;
            event_o  = EV_PRESS;
          end
          if (past_long && (status_d == ST_PRESS)) begin
            status_d = ST_LONG;
            event_o  = EV_LONG;
          end
        end else begin
          case (status_q)
            ST_PRESS: event_o = EV_PRESS_FREE;
            ST_LONG:  event_o = EV_LONG_FREE;
            default:  event_o = EV_NONE;
          endcase
          status_d = ST_NONE;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q  <= 1'b0;
      cnt_q    <= '0;
      status_q <= ST_NONE;
    end else if (en_i) begin
      latch_q  <= latch_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  // A level change always restarts the count
  a_change_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (level_i != latch_q) |=> (cnt_q == '0) && (latch_q == $past(level_i)))
    else $error("counter not restarted on level change");

  // A long press event leaves the button in long-pressed status
  a_long_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (event_o == EV_LONG) |=> status_q == ST_LONG)
    else $error("long press without long status");

  // Any release returns the status to none
  a_release_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && ((event_o == EV_PRESS_FREE) || (event_o == EV_LONG_FREE)) |=> status_q == ST_NONE)
    else $error("release left status set");

endmodule

### bench/button_debounce_long_press_test.sv
// Self-checking bench for button_debounce_long_press: ticks of key levels in, event beats out.
// Keeps its own debouncer model and compares each event beat field by field.
// Depends on bdlp_pkg and the button_debounce_long_press RTL.
`timescale 1ns / 100ps

module button_debounce_long_press_test
  import bdlp_pkg::*;
;

  localparam int unsigned NumKeys = 3;
  // Indexes past the two registers; writes there must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef logic [NumFields-1:0][EventW-1:0] events_t;
  typedef struct {
    logic [LevelsW-1:0] levels;
    int                 gap;
  } tick_t;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [LevelsW-1:0]  key_levels_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [EventW-1:0]   event_0_o;
  logic [EventW-1:0]   event_1_o;
  logic [EventW-1:0]   event_2_o;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;

  button_debounce_long_press #(.NUM_BUTTONS(NumKeys)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .key_levels_i (key_levels_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_0_o    (event_0_o),
    .event_1_o    (event_1_o),
    .event_2_o    (event_2_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Model copy of the registers and of the per-key state
  logic [DebW-1:0]   deb_limit  = DEB_RESET;
  logic [LongW-1:0]  long_limit = LONG_RESET;
  logic              key_latch  [NumKeys] = '{default: 1'b0};
  logic [CountW-1:0] key_ticks  [NumKeys] = '{default: '0};
  logic [1:0]        key_status [NumKeys] = '{default: ST_NONE};

  tick_t   tick_q  [$];
  events_t event_q [$];
  int      gap_cnt    = 0;
  int      stall_cnt  = 0;
  int      sink_max   = 0;
  int      mismatches = 0;

  // One tick of the debouncer for every key; returns the events it raises
  function automatic events_t step_keys(logic [LevelsW-1:0] levels);
    events_t ev;
    logic    lvl;
    ev = '0;
    for (int b = 0; b < NumKeys; b++) begin
      lvl = levels[b];
      if (key_latch[b] != lvl) begin
        key_latch[b] = lvl;
        key_ticks[b] = '0;
      end else begin
        if (key_ticks[b] != '1) key_ticks[b] = key_ticks[b] + 1'b1;
        if (key_ticks[b] > deb_limit) begin
          if (!lvl) begin
            if (key_status[b] == ST_NONE) begin
              key_status[b] = ST_PRESS;
              ev[b] = EV_PRESS;
            end
            // press and long press on one tick report only the long press
            if (key_ticks[b] > long_limit && key_status[b] == ST_PRESS) begin
              key_status[b] = ST_LONG;
              ev[b] = EV_LONG;
            end
          end else begin
            if (key_status[b] == ST_PRESS) ev[b] = EV_PRESS_FREE;
            else if (key_status[b] == ST_LONG) ev[b] = EV_LONG_FREE;
            key_status[b] = ST_NONE;
          end
        end
      end
    end
    return ev;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Tick driver: predicts on each accepted beat, then offers the next after its gap
  always @(posedge clk_i) begin : tick_driver
    logic nxt_valid;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) event_q.push_back(step_keys(key_levels_i));
      if (!in_valid_i || in_ready_o) begin
        nxt_valid = 1'b0;
        if (tick_q.size() > 0) begin
          if (gap_cnt < tick_q[0].gap) begin
            gap_cnt++;
          end else begin
            key_levels_i <= tick_q[0].levels;
            void'(tick_q.pop_front());
            gap_cnt   = 0;
            nxt_valid = 1'b1;
          end
        end
        in_valid_i <= nxt_valid;
      end
    end
  end

  // Event checker with random back-pressure after each beat
  always @(posedge clk_i) begin : event_checker
    events_t seen;
    events_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen = {event_2_o, event_1_o, event_0_o};
        if (event_q.size() == 0) begin
          $error("event beat with no tick outstanding: %h", seen);
          mismatches++;
        end else begin
          want = event_q.pop_front();
          for (int f = 0; f < NumFields; f++) begin
            if (seen[f] !== want[f]) begin
              $error("event_%0d: expected %0d, actual %0d", f, want[f], seen[f]);
              mismatches++;
            end
          end
        end
        stall_cnt = $urandom_range(sink_max, 0);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Register write, mirrored into the model
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DEBOUNCE) deb_limit = data[DebW-1:0];
    else if (idx == CFG_LONG_PRESS) long_limit = data[LongW-1:0];
  endtask

  // Hold one level pattern for a number of ticks
  task automatic queue_hold(logic [LevelsW-1:0] levels, int count, int gap_max);
    tick_t t;
    for (int i = 0; i < count; i++) begin
      t.levels = levels;
      t.gap    = $urandom_range(gap_max, 0);
      tick_q.push_back(t);
    end
  endtask

  // Runs of stable levels scaled to the current limits, mixed with bounces
  task automatic queue_runs(int n, int gap_max);
    logic [LevelsW-1:0] levels;
    int                 run;
    int                 left;
    levels = LevelsW'($urandom_range(7, 0));
    left   = n;
    while (left > 0) begin
      if ($urandom_range(2, 0) == 0) levels = LevelsW'($urandom_range(7, 0));
      else levels[$urandom_range(LevelsW - 1, 0)] ^= 1'b1;
      if ($urandom_range(3, 0) == 0) run = $urandom_range(2, 1);
      else run = $urandom_range(deb_limit + long_limit + 3, 1);
      if (run > left) run = left;
      queue_hold(levels, run, gap_max);
      left -= run;
    end
  endtask

  // Sender pause: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || event_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits: keys start latched low, so a press, then a release
    sink_max = 0;
    queue_hold(3'b000, 25, 0);
    queue_hold(3'b111, 25, 0);
    // Bounce during a press leaves the status alone
    queue_hold(3'b000, 25, 0);
    queue_hold(3'b111, 3, 0);
    queue_hold(3'b000, 10, 0);
    queue_hold(3'b111, 25, 0);
    wait_idle();

    // Zero limits: one stable tick suffices, press and long press together
    sink_max = 11;
    cfg_write(CFG_DEBOUNCE, '0);
    cfg_write(CFG_LONG_PRESS, '0);
    queue_hold(3'b000, 3, 11);
    queue_hold(3'b111, 3, 11);
    queue_hold(3'b101, 2, 11);
    queue_hold(3'b010, 2, 11);
    queue_hold(3'b110, 2, 11);
    queue_hold(3'b001, 2, 11);
    wait_idle();

    // Bits above the register width and unused indexes are ignored
    cfg_write(CFG_DEBOUNCE, 16'hFC03);
    cfg_write(CFG_LONG_PRESS, 16'hFFFF);
    cfg_write(CFG_SPARE_A, CfgDataW'($urandom));
    cfg_write(CFG_SPARE_B, CfgDataW'($urandom));
    queue_hold(3'b000, 8, 11);
    queue_hold(3'b111, 6, 11);
    queue_hold(3'b011, 6, 11);
    wait_idle();

    // Large limits: short holds raise no event
    sink_max = 0;
    cfg_write(CFG_DEBOUNCE, 16'd1000);
    cfg_write(CFG_LONG_PRESS, 16'd65000);
    queue_hold(3'b000, 20, 0);
    queue_hold(3'b111, 20, 0);
    wait_idle();

    // Random phases with small limits so that every status is reached often
    for (int p = 0; p < 8; p++) begin
      cfg_write(CFG_DEBOUNCE, CfgDataW'($urandom_range(6, 0)));
      cfg_write(CFG_LONG_PRESS, CfgDataW'($urandom_range(40, 0)));
      sink_max = (p == 3) ? 0 : 11;
      queue_runs(54, (p == 3) ? 0 : 11);
      if (p == 4) wait_idle();
      queue_runs(54, (p == 3) ? 0 : 11);
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
